// ===== src/sh3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_pkg: shared types and constants for the 3x3 sharpen line filter
// item layouts, register indexes, default sizes and the job record that
// travels from the front end to the arithmetic back end
// ----------------------------------------------------------------------------
package sh3_pkg;

    // default storage sizes
    localparam int MAX_LINE_DEF = 8192;
    localparam int MAX_ROWS_DEF = 4096;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS  = 2'd2;

    localparam int ROW_BYTES_W = 14;
    localparam int ROW_COUNT_W = 13;
    localparam int CHANNELS_W  = 3;

    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 14'd1920;
    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 13'd480;
    localparam logic [CHANNELS_W-1:0]  CHANNELS_RST  = 3'd3;

    // smallest frame side accepted, smaller register values are raised to it
    localparam int MIN_DIM = 3;

    // neighbor offset history: one entry per possible channel count
    localparam int HIST_DEPTH = 7;
    localparam int HIST_IW    = 3;

    // opcodes
    localparam logic OP_IMAGE = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // kernel centre weight
    localparam int CENTRE_WEIGHT = 5;

    // front to back queue
    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = 2;
    localparam int QLEVEL_W = 3;

    typedef struct packed {
        logic       opcode;
        logic [7:0] sample;
    } pix_t;

    typedef struct packed {
        logic [7:0] value;
        logic       end_of_row;
        logic       end_of_frame;
    } res_t;

    typedef struct packed {
        logic       border;
        logic [7:0] centre;
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] up;
        logic [7:0] down;
        logic       end_of_row;
        logic       end_of_frame;
    } job_t;

endpackage

// ===== src/sh3_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_front: item intake, position tracking and line stores
// classifies each item, reads the neighborhood from the line stores and
// hands a complete job record to the queue in the next cycle, not later
// ----------------------------------------------------------------------------
module sh3_front #(
    parameter int MAX_LINE = sh3_pkg::MAX_LINE_DEF,
    parameter int MAX_ROWS = sh3_pkg::MAX_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sh3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sh3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  sh3_pkg::pix_t                  pix,
    input  logic [sh3_pkg::QLEVEL_W-1:0]    q_level,
    output logic                           job_push,
    output sh3_pkg::job_t                  job
);

    localparam int AW   = $clog2(MAX_LINE);
    localparam int RB_W = $clog2(MAX_LINE + 1);
    localparam int CW   = RB_W + 1;
    localparam int RW   = $clog2(MAX_ROWS + 1);

    // configuration
    logic [sh3_pkg::ROW_BYTES_W-1:0] row_bytes_reg;
    logic [sh3_pkg::ROW_COUNT_W-1:0] row_count_reg;
    logic [sh3_pkg::CHANNELS_W-1:0]  channels_reg;

    logic [RB_W-1:0]                 rb_eff;
    logic [RW-1:0]                   rc_eff;
    logic [sh3_pkg::CHANNELS_W-1:0]  ch_eff;

    // positions
    logic [AW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] drain_reg;

    logic          accept;
    logic          in_frame;
    logic          do_line;
    logic          do_drain;
    logic [CW-1:0] col_ext;
    logic [CW-1:0] ch_ext;
    logic [CW-1:0] rb_ext;
    logic          last_col;
    logic          last_drain;
    logic          interior;
    logic [AW-1:0] right_addr;

    // stage after intake
    logic          s1_push_reg;
    logic          s1_line_reg;
    logic          s1_border_reg;
    logic          s1_eor_reg;
    logic          s1_eof_reg;
    logic [7:0]    s1_down_reg;
    logic [AW-1:0] s1_col_reg;

    // line stores and their registered read data
    logic [7:0]    mid_line_mem [MAX_LINE];
    logic [7:0]    upper_line_mem [MAX_LINE];
    logic [7:0]    mid_c_reg;
    logic [7:0]    mid_r_reg;
    logic [7:0]    up_reg;

    // centre values of recent items, for the left neighbor
    logic [7:0]    hist_reg [sh3_pkg::HIST_DEPTH];
    logic [sh3_pkg::HIST_IW-1:0] hist_sel;

    // register clamping
    always_comb
    begin
        if (row_bytes_reg < sh3_pkg::ROW_BYTES_W'(sh3_pkg::MIN_DIM))
            rb_eff = RB_W'(sh3_pkg::MIN_DIM);
        else if (32'(row_bytes_reg) > 32'(MAX_LINE))
            rb_eff = RB_W'(MAX_LINE);
        else
            rb_eff = RB_W'(row_bytes_reg);

        if (row_count_reg < sh3_pkg::ROW_COUNT_W'(sh3_pkg::MIN_DIM))
            rc_eff = RW'(sh3_pkg::MIN_DIM);
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
            rc_eff = RW'(MAX_ROWS);
        else
            rc_eff = RW'(row_count_reg);

        if (channels_reg == '0)
            ch_eff = sh3_pkg::CHANNELS_W'(1);
        else
            ch_eff = channels_reg;
    end

    // room for the item in flight plus this one
    assign pix_stall = (sh3_pkg::QLEVEL_W + 1)'(q_level)
                     + (sh3_pkg::QLEVEL_W + 1)'(s1_push_reg)
                    >= (sh3_pkg::QLEVEL_W + 1)'(sh3_pkg::Q_DEPTH);

    assign accept   = pix_valid && !pix_stall;
    assign in_frame = row_reg < rc_eff;
    assign do_line  = accept && (pix.opcode == sh3_pkg::OP_IMAGE) && in_frame;
    assign do_drain = accept && (pix.opcode == sh3_pkg::OP_DRAIN) && !in_frame;

    assign col_ext    = CW'(col_reg);
    assign ch_ext     = CW'(ch_eff);
    assign rb_ext     = CW'(rb_eff);
    assign last_col   = (col_ext + CW'(1)) >= rb_ext;
    assign last_drain = (CW'(drain_reg) + CW'(1)) >= rb_ext;
    assign interior   = (row_reg > RW'(1)) && (col_ext >= ch_ext)
                     && ((col_ext + ch_ext) < rb_ext);
    assign right_addr = AW'(col_ext + ch_ext);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= sh3_pkg::ROW_BYTES_RST;
            row_count_reg <= sh3_pkg::ROW_COUNT_RST;
            channels_reg  <= sh3_pkg::CHANNELS_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            drain_reg     <= '0;
            s1_push_reg   <= 1'b0;
            s1_line_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sh3_pkg::REG_ROW_BYTES:
                        row_bytes_reg <= cfg_data[sh3_pkg::ROW_BYTES_W-1:0];
                    sh3_pkg::REG_ROW_COUNT:
                        row_count_reg <= cfg_data[sh3_pkg::ROW_COUNT_W-1:0];
                    sh3_pkg::REG_CHANNELS:
                        channels_reg <= cfg_data[sh3_pkg::CHANNELS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (do_line)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + AW'(1);
                end
            end

            if (do_drain)
            begin
                if (last_drain)
                begin
                    drain_reg <= '0;
                    row_reg   <= '0;
                    col_reg   <= '0;
                end
                else
                begin
                    drain_reg <= drain_reg + AW'(1);
                end
            end

            s1_line_reg <= do_line;
            s1_push_reg <= (do_line && (row_reg != '0)) || do_drain;
        end
    end

    // item payload for the next stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_border_reg <= do_drain || !interior;
            s1_eor_reg    <= do_drain ? last_drain : last_col;
            s1_eof_reg    <= do_drain && last_drain;
            s1_down_reg   <= pix.sample;
            s1_col_reg    <= col_reg;
        end
    end

    // middle line: one write, reads at centre and right neighbor
    always_ff @(posedge clk)
    begin
        if (do_line)
        begin
            mid_line_mem[col_reg] <= pix.sample;
            mid_c_reg             <= mid_line_mem[col_reg];
            mid_r_reg             <= mid_line_mem[right_addr];
        end
    end

    // upper line takes the old middle value in the cycle after it is read
    always_ff @(posedge clk)
    begin
        if (do_line)
            up_reg <= upper_line_mem[col_reg];
        if (s1_line_reg)
            upper_line_mem[s1_col_reg] <= mid_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_line_reg)
        begin
            hist_reg[0] <= mid_c_reg;
            for (int i = 1; i < sh3_pkg::HIST_DEPTH; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    assign hist_sel = sh3_pkg::HIST_IW'(ch_eff - sh3_pkg::CHANNELS_W'(1));

    always_comb
    begin
        job.border       = s1_border_reg;
        job.centre       = mid_c_reg;
        job.left         = hist_reg[hist_sel];
        job.right        = mid_r_reg;
        job.up           = up_reg;
        job.down         = s1_down_reg;
        job.end_of_row   = s1_eor_reg;
        job.end_of_frame = s1_eof_reg;
    end

    assign job_push = s1_push_reg;

endmodule

// ===== src/sh3_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_queue: short job queue between front end and back end
// circular buffer with fill level, head shown while not empty
// ----------------------------------------------------------------------------
module sh3_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  sh3_pkg::job_t               push_job,
    input  logic                        pop,
    output logic                        head_valid,
    output sh3_pkg::job_t               head_job,
    output logic [sh3_pkg::QLEVEL_W-1:0] level
);

    sh3_pkg::job_t                    slot_reg [sh3_pkg::Q_DEPTH];
    logic [sh3_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sh3_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sh3_pkg::QLEVEL_W-1:0]     level_reg;
    logic                             do_pop;

    assign head_valid = level_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + sh3_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + sh3_pkg::QPTR_W'(1);
            if (push && !do_pop)
                level_reg <= level_reg + sh3_pkg::QLEVEL_W'(1);
            else if (do_pop && !push)
                level_reg <= level_reg - sh3_pkg::QLEVEL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/sh3_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh3_back: kernel arithmetic and result register
// 5*centre minus four neighbors, clamped to a byte, zero on borders
// ----------------------------------------------------------------------------
module sh3_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  sh3_pkg::job_t head_job,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_stall,
    output sh3_pkg::res_t res
);

    logic [10:0]         weighted;
    logic [9:0]          ring_sum;
    logic signed [11:0]  diff;
    logic [7:0]          clamped;
    logic                res_valid_reg;
    sh3_pkg::res_t       res_reg;

    always_comb
    begin
        weighted = 11'(head_job.centre) * 11'(sh3_pkg::CENTRE_WEIGHT);
        ring_sum = 10'(head_job.left) + 10'(head_job.right)
                 + 10'(head_job.up) + 10'(head_job.down);
        diff     = $signed({1'b0, weighted}) - $signed({2'b00, ring_sum});
        if (head_job.border || diff < 0)
            clamped = 8'd0;
        else if (diff > 12'sd255)
            clamped = 8'hff;
        else
            clamped = diff[7:0];
    end

    assign pop = head_valid && (!res_valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (pop)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg.value        <= clamped;
            res_reg.end_of_row   <= head_job.end_of_row;
            res_reg.end_of_frame <= head_job.end_of_frame;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== src/sharpen_3x3_line_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_line_filter: streaming laplacian sharpen over raster images
// cross kernel, centre weight 5, neighbors -1, byte clamp, zero borders
// ----------------------------------------------------------------------------
// One component byte enters per item and the block sustains one item per
// clock while its intake is not stalled. An image item travels through
// three registers: the intake stage, which holds the classified item
// together with the line-store read data that make up the neighborhood,
// one entry of the four-entry queue between the intake and the arithmetic,
// and the result register after the arithmetic. The intake stalls only
// while that queue cannot take the item in flight plus a new one. The rate
// is set by the middle line store, which is read at the centre and at the
// right neighbor and written with the new byte in the same cycle. Results
// lag the input by one row: the first input row of a frame only fills the
// line stores, and after the last row the same number of drain items
// (opcode 1) give the final all-zero output row, ending with end_of_frame.
// Drain items during a frame and image items after the last row are
// dropped. The line stores need no clearing pass after reset. Write the
// registers only while the block is idle.
// ----------------------------------------------------------------------------
module sharpen_3x3_line_filter #(
    parameter int MAX_LINE = sh3_pkg::MAX_LINE_DEF,
    parameter int MAX_ROWS = sh3_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [sh3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sh3_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  sh3_pkg::pix_t                   pix,
    // result items
    output logic                            res_valid,
    input  logic                            res_stall,
    output sh3_pkg::res_t                   res
);

    // front end to queue
    logic                          job_push;
    sh3_pkg::job_t                 job;
    logic [sh3_pkg::QLEVEL_W-1:0]  q_level;

    // queue to back end
    logic                          head_valid;
    sh3_pkg::job_t                 head_job;
    logic                          pop;

    // intake, positions, line stores
    sh3_front #(
        .MAX_LINE (MAX_LINE),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .q_level   (q_level),
        .job_push  (job_push),
        .job       (job)
    );

    // decouples intake from output back-pressure
    sh3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .level      (q_level)
    );

    // arithmetic and result register
    sh3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // the queue is never pushed while full unless it is popped in the same cycle
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (q_level != sh3_pkg::QLEVEL_W'(sh3_pkg::Q_DEPTH)) || pop)
        else $error("job queue overflow");

    // a full queue holds off new items
    a_full_stalls : assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == sh3_pkg::QLEVEL_W'(sh3_pkg::Q_DEPTH)) |-> pix_stall)
        else $error("intake open while queue full");

    // frame end is a zero item that also closes a row
    a_frame_end : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.end_of_frame) |-> (res.end_of_row && res.value == 8'd0))
        else $error("malformed end of frame item");

endmodule

// ===== verif/sharpen_3x3_line_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_line_filter_tb: self-checking bench for the 3x3 sharpen filter
// streams whole frames of component bytes through the block, predicts every
// filtered component in the bench itself and checks results in order, under
// random idling on both sides, a long output hold-off and many frame sizes
// ----------------------------------------------------------------------------
module sharpen_3x3_line_filter_tb;

    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_AFTER   = 100;   // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;    // cycles after the last result before a write

    // dut ports
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [sh3_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [sh3_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            pix_valid = 1'b0;
    logic                            pix_stall;
    sh3_pkg::pix_t                   pix = '0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    sh3_pkg::res_t                   res;

    // stimulus and checking state
    sh3_pkg::pix_t pending_pix [$];
    sh3_pkg::res_t filtered_due [$];
    sh3_pkg::res_t due_res;
    bit            quiet = 1'b0;       // no idling on either side while set
    int unsigned   results_seen = 0;
    int unsigned   hold_left = 0;
    bit            hold_done = 1'b0;
    int unsigned   mismatch_count = 0;
    int unsigned   random_items = 0;

    // bench copy of the registers and of the filter state
    logic [sh3_pkg::ROW_BYTES_W-1:0] row_bytes_reg = sh3_pkg::ROW_BYTES_RST;
    logic [sh3_pkg::ROW_COUNT_W-1:0] row_count_reg = sh3_pkg::ROW_COUNT_RST;
    logic [sh3_pkg::CHANNELS_W-1:0]  channels_reg  = sh3_pkg::CHANNELS_RST;
    logic [7:0]                      upper_row  [sh3_pkg::MAX_LINE_DEF];
    logic [7:0]                      middle_row [sh3_pkg::MAX_LINE_DEF];
    int unsigned                     col_pos = 0;
    int unsigned                     row_pos = 0;
    int unsigned                     drain_pos = 0;

    sharpen_3x3_line_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // registers as the block sees them: sizes raised or capped into range
    function automatic int unsigned eff_row_bytes();
        if (row_bytes_reg < sh3_pkg::MIN_DIM)
            return sh3_pkg::MIN_DIM;
        if (row_bytes_reg > sh3_pkg::MAX_LINE_DEF)
            return sh3_pkg::MAX_LINE_DEF;
        return row_bytes_reg;
    endfunction

    function automatic int unsigned eff_row_count();
        if (row_count_reg < sh3_pkg::MIN_DIM)
            return sh3_pkg::MIN_DIM;
        if (row_count_reg > sh3_pkg::MAX_ROWS_DEF)
            return sh3_pkg::MAX_ROWS_DEF;
        return row_count_reg;
    endfunction

    function automatic int unsigned eff_channels();
        return (channels_reg == 0) ? 1 : channels_reg;
    endfunction

    // advance the filter by one accepted item and queue the result it gives
    function automatic void sharpen_step(input sh3_pkg::pix_t item);
        int unsigned   rb;
        int unsigned   rc;
        int unsigned   ch;
        int unsigned   c;
        int unsigned   r;
        int            s;
        sh3_pkg::res_t out;
        rb  = eff_row_bytes();
        rc  = eff_row_count();
        ch  = eff_channels();
        out = '0;
        if (item.opcode == sh3_pkg::OP_IMAGE)
        begin
            // image bytes after the last row wait for the drain and are dropped
            if (row_pos >= rc)
                return;
            c = col_pos;
            r = row_pos;
            // the first row only fills the line stores
            if (r >= 1)
            begin
                if (!(r - 1 == 0 || r - 1 == rc - 1 || c < ch || c + ch >= rb))
                begin
                    s = sh3_pkg::CENTRE_WEIGHT * int'(middle_row[c])
                        - int'(upper_row[c - ch]) - int'(upper_row[c])
                        - int'(middle_row[c + ch]) - int'(item.sample);
                    if (s < 0)
                        s = 0;
                    if (s > 255)
                        s = 255;
                    out.value = s[7:0];
                end
                out.end_of_row = (c + 1 >= rb);
                filtered_due.push_back(out);
            end
            upper_row[c]  = middle_row[c];
            middle_row[c] = item.sample;
            if (c + 1 >= rb)
            begin
                col_pos = 0;
                row_pos = r + 1;
            end
            else
                col_pos = c + 1;
        end
        else
        begin
            // drain ticks inside a frame are dropped
            if (row_pos < rc)
                return;
            if (drain_pos + 1 >= rb)
            begin
                out.end_of_row   = 1'b1;
                out.end_of_frame = 1'b1;
                drain_pos = 0;
                row_pos   = 0;
                col_pos   = 0;
            end
            else
                drain_pos = drain_pos + 1;
            filtered_due.push_back(out);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic sh3_pkg::pix_t make_pix(input logic op, input logic [7:0] s);
        sh3_pkg::pix_t item;
        item.opcode = op;
        item.sample = s;
        return item;
    endfunction

    // bytes lean toward 0 and 255 so both clamps are hit often
    function automatic logic [7:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 8'd0;
        if (pick < 30)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // input side: holds an item until taken, then offers the next or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pix       <= '0;
        end
        else
        begin
            if (pix_valid && !pix_stall)
                sharpen_step(pix);
            if (!pix_valid || !pix_stall)
            begin
                if (pending_pix.size() != 0
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    pix       <= pending_pix.pop_front();
                    pix_valid <= 1'b1;
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // output side: checks each taken result and drives the stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (filtered_due.size() == 0)
                    report_mismatch("result with none due, value", res.value, 0);
                else
                begin
                    due_res = filtered_due.pop_front();
                    if (res.value !== due_res.value)
                        report_mismatch("value", res.value, due_res.value);
                    if (res.end_of_row !== due_res.end_of_row)
                        report_mismatch("end_of_row", res.end_of_row, due_res.end_of_row);
                    if (res.end_of_frame !== due_res.end_of_frame)
                        report_mismatch("end_of_frame", res.end_of_frame,
                                        due_res.end_of_frame);
                end
                results_seen <= results_seen + 1;
            end
            // one long hold-off so the block fills up and stalls its input
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                res_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic write_reg(input logic [sh3_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sh3_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // bench copy follows at once, the block is idle here
        if (idx == sh3_pkg::REG_ROW_BYTES)
            row_bytes_reg = data[sh3_pkg::ROW_BYTES_W-1:0];
        else if (idx == sh3_pkg::REG_ROW_COUNT)
            row_count_reg = data[sh3_pkg::ROW_COUNT_W-1:0];
        else if (idx == sh3_pkg::REG_CHANNELS)
            channels_reg = data[sh3_pkg::CHANNELS_W-1:0];
    endtask

    task automatic set_frame(input int unsigned rb, input int unsigned rc,
                             input int unsigned ch);
        write_reg(sh3_pkg::REG_ROW_BYTES, sh3_pkg::CFG_DATA_W'(rb));
        write_reg(sh3_pkg::REG_ROW_COUNT, sh3_pkg::CFG_DATA_W'(rc));
        write_reg(sh3_pkg::REG_CHANNELS, sh3_pkg::CFG_DATA_W'(ch));
    endtask

    // one whole frame with its drain; noise_pct adds items the block drops
    task automatic queue_frame(input int unsigned noise_pct);
        int unsigned rb;
        int unsigned rc;
        rb = eff_row_bytes();
        rc = eff_row_count();
        for (int unsigned i = 0; i < rb * rc; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                pending_pix.push_back(make_pix(sh3_pkg::OP_DRAIN,
                                               8'($urandom_range(0, 255))));
                random_items++;
            end
            pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, rand_sample()));
            random_items++;
        end
        // image bytes while the drain is awaited
        if ($urandom_range(0, 99) < noise_pct * 10)
        begin
            pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, rand_sample()));
            random_items++;
        end
        for (int unsigned i = 0; i < rb; i++)
        begin
            pending_pix.push_back(make_pix(sh3_pkg::OP_DRAIN,
                                           8'($urandom_range(0, 255))));
            random_items++;
        end
    endtask

    // sender pauses until every due result is in, then lets the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_pix.size() != 0 || pix_valid || filtered_due.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int unsigned frames;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3 wide, 4 rows, single channel; centre at full scale over
        // zero neighbors clamps high, zero centre in a ring of 255 clamps low
        set_frame(3, 4, 1);
        @(negedge clk);
        // dropped, frame not done
        pending_pix.push_back(make_pix(sh3_pkg::OP_DRAIN, 8'hff));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd0));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd0));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd0));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd0));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd255));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd0));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd255));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd0));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd255));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd128));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd255));
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd1));
        // dropped, drain awaited
        pending_pix.push_back(make_pix(sh3_pkg::OP_IMAGE, 8'd170));
        pending_pix.push_back(make_pix(sh3_pkg::OP_DRAIN, 8'd0));
        pending_pix.push_back(make_pix(sh3_pkg::OP_DRAIN, 8'd85));
        pending_pix.push_back(make_pix(sh3_pkg::OP_DRAIN, 8'd0));
        wait_idle();

        // deep queue of frames; the long output hold-off lands in here
        set_frame(24, 8, 3);
        @(negedge clk);
        repeat (4) queue_frame(3);
        wait_idle();

        // stretch with no idling on either side
        quiet = 1'b1;
        set_frame(17, 5, 2);
        @(negedge clk);
        repeat (3) queue_frame(0);
        wait_idle();
        quiet = 1'b0;

        // register extremes: zero values raised to the minimum, wide offsets
        set_frame(0, 0, 0);
        @(negedge clk);
        repeat (2) queue_frame(5);
        wait_idle();
        set_frame(5, 3, 7);
        @(negedge clk);
        repeat (2) queue_frame(5);
        wait_idle();
        set_frame(8, 6, 4);
        @(negedge clk);
        queue_frame(5);
        wait_idle();

        // random small frames, out-of-range register values included
        while (random_items < RANDOM_ITEMS)
        begin
            set_frame($urandom_range(0, 24), $urandom_range(0, 8), $urandom_range(0, 7));
            frames = $urandom_range(1, 2);
            @(negedge clk);
            repeat (frames) queue_frame(4);
            wait_idle();
        end

        repeat (SETTLE) @(negedge clk);
        if (filtered_due.size() != 0)
            report_mismatch("results never delivered", 0, filtered_due.size());
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sh3_pkg.sv
src/sh3_front.sv
src/sh3_queue.sv
src/sh3_back.sv
src/sharpen_3x3_line_filter.sv
verif/sharpen_3x3_line_filter_tb.sv
